// ----- rtl/core/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the curvature peak counter.
// ----------------------------------------------------------------------------
package cpc_pkg;

	// Sign of a first difference.
	typedef enum logic [1:0] {
		SLOPE_ZERO = 2'd0,
		SLOPE_POS  = 2'd1,
		SLOPE_NEG  = 2'd2
	} slope_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_LOWER_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_UPPER_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_MIN_PEAKS       = 2'd2;
	localparam logic [1:0] REG_MAX_PEAKS       = 2'd3;

	localparam int          CFG_ADDR_W  = 2;
	localparam int          TALLY_W     = 12;
	localparam logic [11:0] TALLY_MAX   = 12'd4095;
	localparam int          OUT_TDATA_W = 16;
	localparam int          QUEUE_DEPTH = 4;

	// Control part of one queue entry from front to back.
	typedef struct packed {
		logic feed_a;     // first extremum value goes to the counter
		logic feed_b;     // second extremum value goes to the counter
		logic last;       // end of contour: emit a result
		logic too_short;  // contour held a single sample
	} cpc_ctrl_t;

	// An extremum lies between two slopes unless both are strictly of one sign.
	function automatic logic is_extremum(slope_t a, slope_t b);
		return !((a == SLOPE_POS && b == SLOPE_POS) || (a == SLOPE_NEG && b == SLOPE_NEG));
	endfunction

endpackage

// ----- rtl/core/cpc_front.sv -----
// ----------------------------------------------------------------------------
// cpc_front
// Accepts curvature samples, forms slope signs and finds the extrema that
// are released to the counter. Emits one queue entry per released extremum
// or end of contour; the end of a contour can release two extrema.
// ----------------------------------------------------------------------------
module cpc_front import cpc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           last,
	output logic                           push,
	input  logic                           push_ready,
	output cpc_ctrl_t                      push_ctrl,
	output logic signed [SAMPLE_WIDTH-1:0] value_a,
	output logic signed [SAMPLE_WIDTH-1:0] value_b
);

	logic signed [SAMPLE_WIDTH-1:0] hist0_q, hist1_q, pend_q;
	logic                           pend_v_q;
	logic [1:0]                     seen_q;
	slope_t                         slope_q;

	logic                           accept;
	logic signed [SAMPLE_WIDTH:0]   diff_new, diff_old;
	slope_t                         d_cur, d_end;
	logic                           test1, test2, pend_v1;
	logic signed [SAMPLE_WIDTH-1:0] pend1;

	function automatic slope_t slope_of(logic signed [SAMPLE_WIDTH:0] diff);
		if (diff == '0) begin
			return SLOPE_ZERO;
		end else if (diff[SAMPLE_WIDTH]) begin
			return SLOPE_NEG;
		end else begin
			return SLOPE_POS;
		end
	endfunction

	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		diff_new = {sample[SAMPLE_WIDTH-1], sample} - {hist0_q[SAMPLE_WIDTH-1], hist0_q};
		diff_old = {sample[SAMPLE_WIDTH-1], sample} - {hist1_q[SAMPLE_WIDTH-1], hist1_q};
		d_end    = slope_of(diff_new);
		d_cur    = (seen_q == 2'd2) ? slope_of(diff_old) : d_end;
		// Central test at the older sample, then the one-sided test at the end.
		test1    = (seen_q == 2'd2) && is_extremum(slope_q, d_cur);
		pend_v1  = pend_v_q || test1;
		pend1    = test1 ? hist1_q : pend_q;
		test2    = last && (seen_q != 2'd0) && is_extremum(d_cur, d_end);

		push_ctrl.feed_a    = test1 && pend_v_q;
		push_ctrl.feed_b    = test2 && pend_v1;
		push_ctrl.last      = last;
		push_ctrl.too_short = (seen_q == 2'd0);
		value_a             = pend_q;
		value_b             = pend1;
		push = accept && (push_ctrl.feed_a || push_ctrl.feed_b || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 2'd0;
			slope_q  <= SLOPE_ZERO;
			pend_v_q <= 1'b0;
			hist0_q  <= '0;
			hist1_q  <= '0;
			pend_q   <= '0;
		end else if (accept) begin
			if (last) begin
				seen_q   <= 2'd0;
				slope_q  <= SLOPE_ZERO;
				pend_v_q <= 1'b0;
				hist0_q  <= '0;
				hist1_q  <= '0;
				pend_q   <= '0;
			end else begin
				seen_q  <= (seen_q == 2'd0) ? 2'd1 : 2'd2;
				hist0_q <= sample;
				if (seen_q != 2'd0) begin
					slope_q  <= d_cur;
					hist1_q  <= hist0_q;
					pend_v_q <= pend_v1;
					pend_q   <= pend1;
				end
			end
		end
	end

endmodule

// ----- rtl/core/cpc_queue.sv -----
// ----------------------------------------------------------------------------
// cpc_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cpc_queue import cpc_pkg::*; #(
	parameter int WIDTH = 36,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/cpc_back.sv -----
// ----------------------------------------------------------------------------
// cpc_back
// Alternating max/min counter with hysteresis, and the result register.
// ----------------------------------------------------------------------------
module cpc_back import cpc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  cpc_ctrl_t                      q_ctrl,
	input  logic signed [SAMPLE_WIDTH-1:0] q_value_a,
	input  logic signed [SAMPLE_WIDTH-1:0] q_value_b,
	input  logic signed [SAMPLE_WIDTH-1:0] lower_threshold,
	input  logic signed [SAMPLE_WIDTH-1:0] upper_threshold,
	input  logic [TALLY_W-1:0]             min_peaks,
	input  logic [TALLY_W-1:0]             max_peaks,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [TALLY_W-1:0]             peak_count,
	output logic                           count_in_range,
	output logic                           too_short
);

	typedef struct packed {
		logic                           seek;
		logic signed [SAMPLE_WIDTH-1:0] prev;
		logic [TALLY_W-1:0]             tally;
	} cnt_t;

	localparam cnt_t CNT_RESET = '{seek: 1'b1, prev: '0, tally: '0};

	cnt_t cnt_q, cnt_a, cnt_b;
	logic out_v_q;
	logic pop, emit;

	function automatic cnt_t feed(cnt_t c, logic signed [SAMPLE_WIDTH-1:0] v,
			logic signed [SAMPLE_WIDTH-1:0] lo, logic signed [SAMPLE_WIDTH-1:0] up);
		cnt_t r;
		r = c;
		if (c.seek) begin
			if (v < c.prev && c.prev >= up) begin
				r.seek = 1'b0;
				if (c.tally != TALLY_MAX) begin
					r.tally = c.tally + 1'b1;
				end
			end
		end else if (v > c.prev && c.prev < lo) begin
			r.seek = 1'b1;
		end
		r.prev = v;
		return r;
	endfunction

	// The end of a contour can release two extrema, applied in order.
	always_comb begin
		cnt_a = q_ctrl.feed_a ? feed(cnt_q, q_value_a, lower_threshold, upper_threshold) : cnt_q;
		cnt_b = q_ctrl.feed_b ? feed(cnt_a, q_value_b, lower_threshold, upper_threshold) : cnt_a;
	end

	assign q_ready   = !q_ctrl.last || !out_v_q || out_ready;
	assign pop       = q_valid && q_ready;
	assign emit      = pop && q_ctrl.last;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= CNT_RESET;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				cnt_q <= q_ctrl.last ? CNT_RESET : cnt_b;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// A single-sample contour never reports a range hit.
	always_ff @(posedge clk) begin
		if (emit) begin
			peak_count     <= cnt_b.tally;
			count_in_range <= !q_ctrl.too_short && (min_peaks <= cnt_b.tally)
				&& (cnt_b.tally <= max_peaks);
			too_short      <= q_ctrl.too_short;
		end
	end

endmodule

// ----- rtl/core/curvature_peak_counter.sv -----
// ----------------------------------------------------------------------------
// curvature_peak_counter
// Counts alternating curvature peaks along a contour and reports the count
// and a range check on the last sample of each contour.
//
//   Channel  Direction  Beat contents
//   s_*      in         tdata: curvature_sample; tlast: last_sample
//   m_*      out        tdata: peak_count, count_in_range, too_short
//   cfg_*    in         register index and write data, no read-back
//
// One sample is accepted per cycle while the queue has room. For the result
// of a contour, the front writes the queue when the last sample is accepted,
// and the counter loads the result register when it pops that entry.
// A stalled output fills the four-entry queue before s_tready drops.
// Reset clears all contour state and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module curvature_peak_counter import cpc_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// curvature_sample
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// peak_count[11:0], count_in_range, too_short, zero padding
	output logic [OUT_TDATA_W-1:0]           m_tdata,
	input  logic                             cfg_we,
	input  logic [CFG_ADDR_W-1:0]            cfg_addr,
	input  logic [((SAMPLE_WIDTH > TALLY_W) ? SAMPLE_WIDTH : TALLY_W)-1:0] cfg_wdata
);

	localparam int QW = $bits(cpc_ctrl_t) + 2 * SAMPLE_WIDTH;

	logic signed [SAMPLE_WIDTH-1:0] lower_q, upper_q;
	logic [TALLY_W-1:0]             min_q, max_q;

	logic                           push, push_ready, q_valid, q_ready;
	cpc_ctrl_t                      push_ctrl, q_ctrl;
	logic signed [SAMPLE_WIDTH-1:0] value_a, value_b, q_value_a, q_value_b;
	logic [QW-1:0]                  q_wdata, q_rdata;
	logic [TALLY_W-1:0]             peak_count;
	logic                           count_in_range, too_short;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
			min_q   <= '0;
			max_q   <= TALLY_MAX;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LOWER_THRESHOLD: lower_q <= cfg_wdata[SAMPLE_WIDTH-1:0];
				REG_UPPER_THRESHOLD: upper_q <= cfg_wdata[SAMPLE_WIDTH-1:0];
				REG_MIN_PEAKS:       min_q   <= cfg_wdata[TALLY_W-1:0];
				REG_MAX_PEAKS:       max_q   <= cfg_wdata[TALLY_W-1:0];
				default: ;
			endcase
		end
	end

	cpc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.sample     (s_tdata[SAMPLE_WIDTH-1:0]),
		.last       (s_tlast),
		.push       (push),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.value_a    (value_a),
		.value_b    (value_b)
	);

	assign q_wdata = {push_ctrl, value_b, value_a};

	cpc_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (push_ready),
		.wr_data  (q_wdata),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (q_rdata)
	);

	assign q_value_a = q_rdata[SAMPLE_WIDTH-1:0];
	assign q_value_b = q_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign q_ctrl    = q_rdata[QW-1:2*SAMPLE_WIDTH];

	cpc_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_ready         (q_ready),
		.q_ctrl          (q_ctrl),
		.q_value_a       (q_value_a),
		.q_value_b       (q_value_b),
		.lower_threshold (lower_q),
		.upper_threshold (upper_q),
		.min_peaks       (min_q),
		.max_peaks       (max_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.peak_count      (peak_count),
		.count_in_range  (count_in_range),
		.too_short       (too_short)
	);

	assign m_tdata = {2'b00, too_short, count_in_range, peak_count};

endmodule

// ----- rtl/core/cpc_checker.sv -----
// ----------------------------------------------------------------------------
// cpc_checker
// Port-level checks on the result channel of the curvature peak counter.
// ----------------------------------------------------------------------------
module cpc_checker import cpc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result beat keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A single-sample contour reports no peaks and no range hit.
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[13] |-> m_tdata[11:0] == 12'd0 && !m_tdata[12])
		else $error("too_short result with nonzero count or range flag");

	// No result is offered while in reset.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// Padding bits of the result stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:14] == 2'b00)
		else $error("result padding not zero");

endmodule

bind curvature_peak_counter cpc_checker u_cpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
